// File: rtl/ctrc_pkg.sv
// shared widths, codes, reset values and types of the chunked transfer retry controller
`timescale 1ns / 1ps

package ctrc_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned MIN_W      = 13;
  localparam int unsigned LIMIT_W    = 5;
  localparam int unsigned BUSY_W     = 17;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ECODE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned ERROR_WINDOW_BITS_DEF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_MAX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_TIMEOUT = 3'd5;

  // register reset values
  localparam logic [SIZE_W-1:0]  RST_PROTO_MAX    = 16'd0;
  localparam logic [MIN_W-1:0]   RST_MIN_SIZE     = 13'd1;
  localparam logic [SIZE_W-1:0]  RST_REGION_MAX   = 16'd65535;
  localparam logic [LIMIT_W-1:0] RST_ERR_LIMIT    = 5'd3;
  localparam logic [SIZE_W-1:0]  RST_BUSY_STEP    = 16'd10;
  localparam logic [SIZE_W-1:0]  RST_BUSY_TIMEOUT = 16'd1000;

  // input operations
  localparam logic OP_START    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // response status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LINK  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OTHER = 2'd3;

  // result actions
  localparam logic [ACTION_W-1:0] ACT_ISSUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DONE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FAIL  = 2'd2;

  // error codes
  localparam logic [ECODE_W-1:0] ERR_NONE         = 3'd0;
  localparam logic [ECODE_W-1:0] ERR_NO_PROTOCOL  = 3'd1;
  localparam logic [ECODE_W-1:0] ERR_BAD_SIZE     = 3'd2;
  localparam logic [ECODE_W-1:0] ERR_BAD_ADDRESS  = 3'd3;
  localparam logic [ECODE_W-1:0] ERR_DISCONNECTED = 3'd4;
  localparam logic [ECODE_W-1:0] ERR_BUSY_TIMEOUT = 3'd5;
  localparam logic [ECODE_W-1:0] ERR_OTHER        = 3'd6;

  localparam logic [BUSY_W-1:0] BUSY_SAT = {BUSY_W{1'b1}};

  typedef struct packed {
    logic [SIZE_W-1:0]  proto_max;
    logic [MIN_W-1:0]   min_size;     // zero already mapped to one
    logic [SIZE_W-1:0]  region_max;
    logic [LIMIT_W-1:0] err_limit;
    logic [SIZE_W-1:0]  busy_step;
    logic [SIZE_W-1:0]  busy_timeout;
  } cfg_t;

endpackage

// File: rtl/ctrc_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps

module ctrc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ctrc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ctrc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output ctrc_pkg::cfg_t                   cfg_o
);

  logic [ctrc_pkg::SIZE_W-1:0]  proto_max_q;
  logic [ctrc_pkg::MIN_W-1:0]   min_size_q;
  logic [ctrc_pkg::SIZE_W-1:0]  region_max_q;
  logic [ctrc_pkg::LIMIT_W-1:0] err_limit_q;
  logic [ctrc_pkg::SIZE_W-1:0]  busy_step_q;
  logic [ctrc_pkg::SIZE_W-1:0]  busy_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_max_q    <= ctrc_pkg::RST_PROTO_MAX;
      min_size_q     <= ctrc_pkg::RST_MIN_SIZE;
      region_max_q   <= ctrc_pkg::RST_REGION_MAX;
      err_limit_q    <= ctrc_pkg::RST_ERR_LIMIT;
      busy_step_q    <= ctrc_pkg::RST_BUSY_STEP;
      busy_timeout_q <= ctrc_pkg::RST_BUSY_TIMEOUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ctrc_pkg::REG_PROTO_MAX:    proto_max_q    <= cfg_data_i;
        ctrc_pkg::REG_MIN_SIZE:     min_size_q     <= cfg_data_i[ctrc_pkg::MIN_W-1:0];
        ctrc_pkg::REG_REGION_MAX:   region_max_q   <= cfg_data_i;
        ctrc_pkg::REG_ERR_LIMIT:    err_limit_q    <= cfg_data_i[ctrc_pkg::LIMIT_W-1:0];
        ctrc_pkg::REG_BUSY_STEP:    busy_step_q    <= cfg_data_i;
        ctrc_pkg::REG_BUSY_TIMEOUT: busy_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.proto_max    = proto_max_q;
    // a zero granularity acts as one
    cfg_o.min_size     = (min_size_q == '0) ? ctrc_pkg::MIN_W'(1) : min_size_q;
    cfg_o.region_max   = region_max_q;
    cfg_o.err_limit    = err_limit_q;
    cfg_o.busy_step    = busy_step_q;
    cfg_o.busy_timeout = busy_timeout_q;
  end

endmodule

// File: rtl/ctrc_rem_unit.sv
// shared bit-serial remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module ctrc_rem_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ctrc_pkg::ADDR_W-1:0]   dividend_i,
  input  logic [ctrc_pkg::MIN_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [ctrc_pkg::MIN_W-1:0]    rem_o
);

  localparam int unsigned CNT_W = $clog2(ctrc_pkg::ADDR_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [ctrc_pkg::ADDR_W-1:0] dvd_q, dvd_d;
  logic [ctrc_pkg::MIN_W-1:0]  dvs_q, dvs_d;
  logic [ctrc_pkg::MIN_W-1:0]  rem_q, rem_d;
  logic [ctrc_pkg::MIN_W:0]    trial;

  // partial remainder stays below the divisor, so the trial fits one extra bit
  assign trial = {rem_q, dvd_q[ctrc_pkg::ADDR_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = ctrc_pkg::MIN_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[ctrc_pkg::MIN_W-1:0];
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ctrc_pkg::ADDR_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/ctrc_err_window.sv
// sliding link error window with a running count of set bits
`timescale 1ns / 1ps

module ctrc_err_window #(
  parameter int unsigned WIN_BITS = ctrc_pkg::ERROR_WINDOW_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           shift_i,
  input  logic                           set_i,
  output logic [$clog2(WIN_BITS+1)-1:0]  count_next_o
);

  localparam int unsigned CNT_W = $clog2(WIN_BITS + 1);

  logic [WIN_BITS-1:0] win_q, win_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    cnt_shift;

  // the oldest bit drops out, the new one comes in
  assign cnt_shift = cnt_q - CNT_W'(win_q[WIN_BITS-1]) + CNT_W'(set_i);

  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    if (clear_i) begin
      win_d = '0;
      cnt_d = '0;
    end else if (shift_i) begin
      win_d = (win_q << 1) | WIN_BITS'(set_i);
      cnt_d = cnt_shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
    end else begin
      win_q <= win_d;
      cnt_q <= cnt_d;
    end
  end

  assign count_next_o = cnt_shift;

endmodule

// File: rtl/chunked_transfer_retry_controller.sv
// top level: transfer sequencer around the shared remainder unit
//
// Input channel (in_valid_i / in_stall_o) takes one item: a start with address
// and length, or the response to the last chunk request. Output channel
// (out_valid_o / out_stall_i) gives one result per item: a chunk request, done
// or failed with an error code. A response while no transfer runs gives none.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write it only while idle, the block itself does not enforce this. A start
// runs the bit-serial remainder unit on the address, the length and the protocol
// size in turn (each modulo the granularity), then derives the chunk limit; a
// failed check ends it sooner. in_stall_o is high while an item is worked on.
// A finished result sits in the output register; the next item is accepted
// meanwhile, and its result waits until the receiver drops out_stall_i.
// Reset clears the configuration to defaults and leaves the block idle.
`timescale 1ns / 1ps

module chunked_transfer_retry_controller #(
  parameter int unsigned ERROR_WINDOW_BITS = ctrc_pkg::ERROR_WINDOW_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ctrc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ctrc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [ctrc_pkg::ADDR_W-1:0]       start_address_i,
  input  logic [ctrc_pkg::LEN_W-1:0]        transfer_length_i,
  input  logic [ctrc_pkg::STATUS_W-1:0]     response_status_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ctrc_pkg::ACTION_W-1:0]     action_o,
  output logic [ctrc_pkg::ADDR_W-1:0]       chunk_address_o,
  output logic [ctrc_pkg::SIZE_W-1:0]       chunk_size_o,
  output logic                              sleep_first_o,
  output logic [ctrc_pkg::ECODE_W-1:0]      error_code_o
);

  localparam int unsigned WCNT_W = $clog2(ERROR_WINDOW_BITS + 1);
  localparam int unsigned CMP_W  = (WCNT_W > ctrc_pkg::LIMIT_W) ? WCNT_W : ctrc_pkg::LIMIT_W;
  localparam int unsigned ST_W   = 4;

  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_CHECK  = 4'd1;
  localparam logic [ST_W-1:0] S_REM_A  = 4'd2;
  localparam logic [ST_W-1:0] S_REM_L  = 4'd3;
  localparam logic [ST_W-1:0] S_REM_P  = 4'd4;
  localparam logic [ST_W-1:0] S_LIMIT  = 4'd5;
  localparam logic [ST_W-1:0] S_LIMCHK = 4'd6;
  localparam logic [ST_W-1:0] S_PICK   = 4'd7;
  localparam logic [ST_W-1:0] S_RESP   = 4'd8;
  localparam logic [ST_W-1:0] S_OKFIN  = 4'd9;
  localparam logic [ST_W-1:0] S_EMIT   = 4'd10;

  ctrc_pkg::cfg_t cfg;

  logic [ST_W-1:0] state_q, state_d;

  // accepted item
  logic [ctrc_pkg::ADDR_W-1:0]   addr_q;
  logic [ctrc_pkg::LEN_W-1:0]    len_q;
  logic [ctrc_pkg::STATUS_W-1:0] status_q;

  // transfer state
  logic                          active_q, active_d;
  logic [ctrc_pkg::ADDR_W-1:0]   next_addr_q, next_addr_d;
  logic [ctrc_pkg::LEN_W-1:0]    bytes_q, bytes_d;
  logic [ctrc_pkg::SIZE_W-1:0]   chunk_q, chunk_d;
  logic [ctrc_pkg::SIZE_W-1:0]   limit_q, limit_d;
  logic [ctrc_pkg::BUSY_W-1:0]   busy_q, busy_d;

  // pending result
  logic [ctrc_pkg::ACTION_W-1:0] res_act_q, res_act_d;
  logic [ctrc_pkg::ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic [ctrc_pkg::SIZE_W-1:0]   res_size_q, res_size_d;
  logic                          res_sleep_q, res_sleep_d;
  logic [ctrc_pkg::ECODE_W-1:0]  res_code_q, res_code_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [ctrc_pkg::ACTION_W-1:0] out_act_q;
  logic [ctrc_pkg::ADDR_W-1:0]   out_addr_q;
  logic [ctrc_pkg::SIZE_W-1:0]   out_size_q;
  logic                          out_sleep_q;
  logic [ctrc_pkg::ECODE_W-1:0]  out_code_q;
  logic                          out_load;

  logic                          in_accept;
  logic                          rem_start;
  logic [ctrc_pkg::ADDR_W-1:0]   rem_dividend;
  logic                          rem_done;
  logic [ctrc_pkg::MIN_W-1:0]    rem;
  logic                          win_clear, win_shift, win_set;
  logic [WCNT_W-1:0]             win_count_next;

  logic [ctrc_pkg::SIZE_W-1:0]   proto_floor;
  logic [ctrc_pkg::BUSY_W:0]     busy_sum;
  logic [ctrc_pkg::BUSY_W-1:0]   busy_sat;
  logic [ctrc_pkg::SIZE_W-1:0]   pick;

  ctrc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ctrc_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (cfg.min_size),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  ctrc_err_window #(
    .WIN_BITS (ERROR_WINDOW_BITS)
  ) u_win (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (win_clear),
    .shift_i      (win_shift),
    .set_i        (win_set),
    .count_next_o (win_count_next)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  assign proto_floor = cfg.proto_max - ctrc_pkg::SIZE_W'(rem);
  assign busy_sum    = {1'b0, busy_q} + (ctrc_pkg::BUSY_W + 1)'(cfg.busy_step);
  assign busy_sat    = busy_sum[ctrc_pkg::BUSY_W] ? ctrc_pkg::BUSY_SAT
                                                  : busy_sum[ctrc_pkg::BUSY_W-1:0];
  assign pick        = (bytes_q < ctrc_pkg::LEN_W'(limit_q)) ? ctrc_pkg::SIZE_W'(bytes_q)
                                                             : limit_q;

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    next_addr_d  = next_addr_q;
    bytes_d      = bytes_q;
    chunk_d      = chunk_q;
    limit_d      = limit_q;
    busy_d       = busy_q;
    res_act_d    = res_act_q;
    res_addr_d   = res_addr_q;
    res_size_d   = res_size_q;
    res_sleep_d  = res_sleep_q;
    res_code_d   = res_code_q;
    rem_start    = 1'b0;
    rem_dividend = addr_q;
    win_clear    = 1'b0;
    win_shift    = 1'b0;
    win_set      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (op_i == ctrc_pkg::OP_START) ? S_CHECK : S_RESP;
        end
      end

      S_CHECK: begin
        active_d    = 1'b0;
        res_act_d   = ctrc_pkg::ACT_FAIL;
        res_addr_d  = '0;
        res_size_d  = '0;
        res_sleep_d = 1'b0;
        state_d     = S_EMIT;
        if (cfg.proto_max == '0) begin
          res_code_d = ctrc_pkg::ERR_NO_PROTOCOL;
        end else if (len_q == '0) begin
          res_code_d = ctrc_pkg::ERR_BAD_SIZE;
        end else if ((len_q - ctrc_pkg::LEN_W'(1)) > ~addr_q) begin
          // last byte would pass the top of the address space
          res_code_d = ctrc_pkg::ERR_BAD_ADDRESS;
        end else begin
          rem_start = 1'b1;
          state_d   = S_REM_A;
        end
      end

      S_REM_A: begin
        if (rem_done) begin
          if (rem != '0) begin
            res_code_d = ctrc_pkg::ERR_BAD_ADDRESS;
            state_d    = S_EMIT;
          end else begin
            rem_start    = 1'b1;
            rem_dividend = len_q;
            state_d      = S_REM_L;
          end
        end
      end

      S_REM_L: begin
        if (rem_done) begin
          if (rem != '0) begin
            res_code_d = ctrc_pkg::ERR_BAD_SIZE;
            state_d    = S_EMIT;
          end else begin
            rem_start    = 1'b1;
            rem_dividend = ctrc_pkg::ADDR_W'(cfg.proto_max);
            state_d      = S_REM_P;
          end
        end
      end

      S_REM_P: begin
        if (rem_done) begin
          state_d = S_LIMIT;
        end
      end

      S_LIMIT: begin
        limit_d = (cfg.region_max < proto_floor) ? cfg.region_max : proto_floor;
        state_d = S_LIMCHK;
      end

      S_LIMCHK: begin
        if (limit_q == '0) begin
          res_code_d = ctrc_pkg::ERR_NO_PROTOCOL;
          state_d    = S_EMIT;
        end else begin
          active_d    = 1'b1;
          next_addr_d = addr_q;
          bytes_d     = len_q;
          busy_d      = '0;
          win_clear   = 1'b1;
          state_d     = S_PICK;
        end
      end

      S_PICK: begin
        chunk_d     = pick;
        res_act_d   = ctrc_pkg::ACT_ISSUE;
        res_addr_d  = next_addr_q;
        res_size_d  = pick;
        res_sleep_d = 1'b0;
        res_code_d  = ctrc_pkg::ERR_NONE;
        state_d     = S_EMIT;
      end

      S_RESP: begin
        if (!active_q) begin
          state_d = S_IDLE;
        end else begin
          win_shift   = 1'b1;
          res_act_d   = ctrc_pkg::ACT_ISSUE;
          res_addr_d  = next_addr_q;
          res_size_d  = chunk_q;
          res_sleep_d = 1'b0;
          res_code_d  = ctrc_pkg::ERR_NONE;
          state_d     = S_EMIT;
          case (status_q)
            ctrc_pkg::ST_OK: begin
              next_addr_d = next_addr_q + ctrc_pkg::ADDR_W'(chunk_q);
              bytes_d     = bytes_q - ctrc_pkg::LEN_W'(chunk_q);
              state_d     = S_OKFIN;
            end
            ctrc_pkg::ST_LINK: begin
              win_set = 1'b1;
              if (CMP_W'(win_count_next) > CMP_W'(cfg.err_limit)) begin
                active_d    = 1'b0;
                res_act_d   = ctrc_pkg::ACT_FAIL;
                res_addr_d  = '0;
                res_size_d  = '0;
                res_code_d  = ctrc_pkg::ERR_DISCONNECTED;
              end
            end
            ctrc_pkg::ST_BUSY: begin
              busy_d = busy_sat;
              if (busy_sat < ctrc_pkg::BUSY_W'(cfg.busy_timeout)) begin
                res_sleep_d = 1'b1;
              end else begin
                active_d    = 1'b0;
                res_act_d   = ctrc_pkg::ACT_FAIL;
                res_addr_d  = '0;
                res_size_d  = '0;
                res_code_d  = ctrc_pkg::ERR_BUSY_TIMEOUT;
              end
            end
            default: begin
              active_d    = 1'b0;
              res_act_d   = ctrc_pkg::ACT_FAIL;
              res_addr_d  = '0;
              res_size_d  = '0;
              res_code_d  = ctrc_pkg::ERR_OTHER;
            end
          endcase
        end
      end

      S_OKFIN: begin
        if (bytes_q == '0) begin
          active_d    = 1'b0;
          chunk_d     = '0;
          res_act_d   = ctrc_pkg::ACT_DONE;
          res_addr_d  = '0;
          res_size_d  = '0;
          res_sleep_d = 1'b0;
          res_code_d  = ctrc_pkg::ERR_NONE;
          state_d     = S_EMIT;
        end else begin
          state_d = S_PICK;
        end
      end

      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      next_addr_q <= '0;
      bytes_q     <= '0;
      chunk_q     <= '0;
      limit_q     <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      next_addr_q <= next_addr_d;
      bytes_q     <= bytes_d;
      chunk_q     <= chunk_d;
      limit_q     <= limit_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q   <= start_address_i;
      len_q    <= transfer_length_i;
      status_q <= response_status_i;
    end
    res_act_q   <= res_act_d;
    res_addr_q  <= res_addr_d;
    res_size_q  <= res_size_d;
    res_sleep_q <= res_sleep_d;
    res_code_q  <= res_code_d;
    if (out_load) begin
      out_act_q   <= res_act_q;
      out_addr_q  <= res_addr_q;
      out_size_q  <= res_size_q;
      out_sleep_q <= res_sleep_q;
      out_code_q  <= res_code_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_act_q;
  assign chunk_address_o = out_addr_q;
  assign chunk_size_o    = out_size_q;
  assign sleep_first_o   = out_sleep_q;
  assign error_code_o    = out_code_q;

endmodule

// File: tb/sv/chunked_transfer_retry_controller_tb.sv
// self-checking testbench of the chunked transfer retry controller
`timescale 1ns / 1ps

module chunked_transfer_retry_controller_tb;

  localparam int unsigned WIN_BITS       = ctrc_pkg::ERROR_WINDOW_BITS_DEF;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned PHASE_ITEMS    = 110;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned STEADY_PHASE   = 4;
  localparam int unsigned MAX_RESPONSES  = 40;

  typedef struct packed {
    logic [ctrc_pkg::ACTION_W-1:0] action;
    logic [ctrc_pkg::ADDR_W-1:0]   chunk_address;
    logic [ctrc_pkg::SIZE_W-1:0]   chunk_size;
    logic                          sleep_first;
    logic [ctrc_pkg::ECODE_W-1:0]  error_code;
  } chunk_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [ctrc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ctrc_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic                            op_i;
  logic [ctrc_pkg::ADDR_W-1:0]     start_address_i;
  logic [ctrc_pkg::LEN_W-1:0]      transfer_length_i;
  logic [ctrc_pkg::STATUS_W-1:0]   response_status_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [ctrc_pkg::ACTION_W-1:0]   action_o;
  logic [ctrc_pkg::ADDR_W-1:0]     chunk_address_o;
  logic [ctrc_pkg::SIZE_W-1:0]     chunk_size_o;
  logic                            sleep_first_o;
  logic [ctrc_pkg::ECODE_W-1:0]    error_code_o;

  chunked_transfer_retry_controller dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .start_address_i   (start_address_i),
    .transfer_length_i (transfer_length_i),
    .response_status_i (response_status_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .action_o          (action_o),
    .chunk_address_o   (chunk_address_o),
    .chunk_size_o      (chunk_size_o),
    .sleep_first_o     (sleep_first_o),
    .error_code_o      (error_code_o)
  );

  // register copies
  logic [ctrc_pkg::SIZE_W-1:0]  cfg_proto;
  logic [ctrc_pkg::MIN_W-1:0]   cfg_min;
  logic [ctrc_pkg::SIZE_W-1:0]  cfg_rmax;
  logic [ctrc_pkg::LIMIT_W-1:0] cfg_elimit;
  logic [ctrc_pkg::SIZE_W-1:0]  cfg_step;
  logic [ctrc_pkg::SIZE_W-1:0]  cfg_timeout;

  // transfer state of the predictor
  logic [ctrc_pkg::ADDR_W-1:0] next_addr;
  logic [ctrc_pkg::LEN_W-1:0]  bytes_left;
  logic [ctrc_pkg::SIZE_W-1:0] cur_chunk;
  logic [WIN_BITS-1:0]         err_win;
  logic [ctrc_pkg::BUSY_W-1:0] busy_spent;
  logic                        xfer_active;
  logic [ctrc_pkg::SIZE_W-1:0] chunk_lim;

  chunk_result_t pending_results[$];
  int unsigned   items_sent;
  int unsigned   fail_count;
  int unsigned   quiet_cycles;
  bit            idling;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side: random stall
  always @(posedge clk_i) begin
    out_stall_i <= idling && ($urandom_range(99) < 30);
  end

  // result checker
  always @(posedge clk_i) begin
    chunk_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: action %0d address %0h size %0d",
               action_o, chunk_address_o, chunk_size_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (action_o !== want.action) begin
          $error("action: expected %0d, actual %0d", want.action, action_o);
          fail_count++;
        end
        if (chunk_address_o !== want.chunk_address) begin
          $error("chunk_address: expected %0h, actual %0h", want.chunk_address,
                 chunk_address_o);
          fail_count++;
        end
        if (chunk_size_o !== want.chunk_size) begin
          $error("chunk_size: expected %0d, actual %0d", want.chunk_size, chunk_size_o);
          fail_count++;
        end
        if (sleep_first_o !== want.sleep_first) begin
          $error("sleep_first: expected %0d, actual %0d", want.sleep_first, sleep_first_o);
          fail_count++;
        end
        if (error_code_o !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code, error_code_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("chunked_transfer_retry_controller regression: fail");
      $finish;
    end
  end

  task automatic push_issue(input logic sleep);
    chunk_result_t r;
    r.action        = ctrc_pkg::ACT_ISSUE;
    r.chunk_address = next_addr;
    r.chunk_size    = cur_chunk;
    r.sleep_first   = sleep;
    r.error_code    = ctrc_pkg::ERR_NONE;
    pending_results.push_back(r);
  endtask

  task automatic push_end(input logic [ctrc_pkg::ACTION_W-1:0] act,
                          input logic [ctrc_pkg::ECODE_W-1:0] code);
    chunk_result_t r;
    xfer_active     = 1'b0;
    r.action        = act;
    r.chunk_address = '0;
    r.chunk_size    = '0;
    r.sleep_first   = 1'b0;
    r.error_code    = code;
    pending_results.push_back(r);
  endtask

  task automatic take_chunk();
    cur_chunk = (bytes_left < ctrc_pkg::LEN_W'(chunk_lim)) ? bytes_left[ctrc_pkg::SIZE_W-1:0]
                                                          : chunk_lim;
  endtask

  // predicts the result of one accepted item
  task automatic model_item(input logic op, input logic [ctrc_pkg::ADDR_W-1:0] addr,
                            input logic [ctrc_pkg::LEN_W-1:0] len,
                            input logic [ctrc_pkg::STATUS_W-1:0] status);
    logic [31:0] minsz;
    logic [31:0] proto_r;
    logic [17:0] busy_sum;
    if (op == ctrc_pkg::OP_START) begin
      minsz = (cfg_min == '0) ? 32'd1 : 32'(cfg_min);
      xfer_active = 1'b0;
      if (cfg_proto == '0) begin
        push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_NO_PROTOCOL);
      end else if (len == '0) begin
        push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_BAD_SIZE);
      end else if (len - 32'd1 > 32'hFFFF_FFFF - addr) begin
        push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_BAD_ADDRESS);
      end else if (addr % minsz != 0) begin
        push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_BAD_ADDRESS);
      end else if (len % minsz != 0) begin
        push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_BAD_SIZE);
      end else begin
        proto_r   = (32'(cfg_proto) / minsz) * minsz;
        chunk_lim = (32'(cfg_rmax) < proto_r) ? cfg_rmax : proto_r[ctrc_pkg::SIZE_W-1:0];
        if (chunk_lim == '0) begin
          push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_NO_PROTOCOL);
        end else begin
          next_addr   = addr;
          bytes_left  = len;
          err_win     = '0;
          busy_spent  = '0;
          xfer_active = 1'b1;
          take_chunk();
          push_issue(1'b0);
        end
      end
    end else if (xfer_active) begin
      err_win = err_win << 1;
      case (status)
        ctrc_pkg::ST_OK: begin
          next_addr  = next_addr + ctrc_pkg::ADDR_W'(cur_chunk);
          bytes_left = bytes_left - ctrc_pkg::LEN_W'(cur_chunk);
          if (bytes_left == '0) begin
            cur_chunk = '0;
            push_end(ctrc_pkg::ACT_DONE, ctrc_pkg::ERR_NONE);
          end else begin
            take_chunk();
            push_issue(1'b0);
          end
        end
        ctrc_pkg::ST_LINK: begin
          err_win[0] = 1'b1;
          if ($countones(err_win) <= cfg_elimit) begin
            push_issue(1'b0);
          end else begin
            push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_DISCONNECTED);
          end
        end
        ctrc_pkg::ST_BUSY: begin
          busy_sum   = 18'(busy_spent) + 18'(cfg_step);
          busy_spent = (busy_sum > 18'(ctrc_pkg::BUSY_SAT)) ? ctrc_pkg::BUSY_SAT
                                                             : busy_sum[ctrc_pkg::BUSY_W-1:0];
          if (busy_spent < ctrc_pkg::BUSY_W'(cfg_timeout)) begin
            push_issue(1'b1);
          end else begin
            push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_BUSY_TIMEOUT);
          end
        end
        default: begin
          push_end(ctrc_pkg::ACT_FAIL, ctrc_pkg::ERR_OTHER);
        end
      endcase
    end
  endtask

  // offers one item and holds it until the block takes it
  task automatic send_item(input logic op, input logic [ctrc_pkg::ADDR_W-1:0] addr,
                           input logic [ctrc_pkg::LEN_W-1:0] len,
                           input logic [ctrc_pkg::STATUS_W-1:0] status);
    int gap;
    if (idling && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_i              <= op;
    start_address_i   <= addr;
    transfer_length_i <= len;
    response_status_i <= status;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // a response while idle is dropped by the block and not counted
    if (op == ctrc_pkg::OP_START || xfer_active) items_sent++;
    model_item(op, addr, len, status);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [ctrc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [ctrc_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] proto, input logic [15:0] minv,
                                input logic [15:0] rmax, input logic [15:0] elim,
                                input logic [15:0] step, input logic [15:0] tmo);
    settle();
    put_reg(ctrc_pkg::REG_PROTO_MAX, proto);
    put_reg(ctrc_pkg::REG_MIN_SIZE, minv);
    put_reg(ctrc_pkg::REG_REGION_MAX, rmax);
    put_reg(ctrc_pkg::REG_ERR_LIMIT, elim);
    put_reg(ctrc_pkg::REG_BUSY_STEP, step);
    put_reg(ctrc_pkg::REG_BUSY_TIMEOUT, tmo);
    cfg_we_i    <= 1'b0;
    cfg_proto   = proto;
    cfg_min     = minv[ctrc_pkg::MIN_W-1:0];
    cfg_rmax    = rmax;
    cfg_elimit  = elim[ctrc_pkg::LIMIT_W-1:0];
    cfg_step    = step;
    cfg_timeout = tmo;
  endtask

  task automatic test_reset_defaults();
    // protocol size is zero after reset
    send_item(ctrc_pkg::OP_START, 32'h0, 32'd16, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_RESPONSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ctrc_pkg::ST_OK);
  endtask

  task automatic test_start_checks();
    apply_settings(16'd64, 16'd4, 16'd65535, 16'd3, 16'd10, 16'd1000);
    send_item(ctrc_pkg::OP_START, 32'h0, 32'd0, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_START, 32'hFFFF_FFFC, 32'd8, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_START, 32'h2, 32'd8, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_START, 32'h0, 32'd6, ctrc_pkg::ST_OK);
    // range ending exactly at the top of the address space
    send_item(ctrc_pkg::OP_START, 32'hFFFF_FFFC, 32'd4, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_START, 32'h100, 32'd200, ctrc_pkg::ST_OTHER);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_LINK);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_BUSY);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_OK);
    // start while a transfer runs
    send_item(ctrc_pkg::OP_START, 32'h1000, 32'd8, ctrc_pkg::ST_BUSY);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_OTHER);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_OK);
    // protocol size below the granularity leaves no usable chunk
    apply_settings(16'd3, 16'd4, 16'd65535, 16'd3, 16'd10, 16'd1000);
    send_item(ctrc_pkg::OP_START, 32'h0, 32'd4, ctrc_pkg::ST_OK);
  endtask

  task automatic test_limits();
    // zero granularity acts as one
    apply_settings(16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd1);
    send_item(ctrc_pkg::OP_START, 32'h0, 32'hFFFF_FFFF, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_BUSY);
    send_item(ctrc_pkg::OP_START, 32'h7, 32'd3, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_LINK);
    apply_settings(16'd65535, 16'd4096, 16'd1, 16'd16, 16'd1, 16'd65535);
    send_item(ctrc_pkg::OP_START, 32'h1000, 32'h1000, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_LINK);
    send_item(ctrc_pkg::OP_RESPONSE, 32'h0, 32'h0, ctrc_pkg::ST_OK);
    send_item(ctrc_pkg::OP_START, 32'hFFFF_F000, 32'h1000, ctrc_pkg::ST_OK);
  endtask

  // one well-formed transfer with random content, sometimes cut short
  task automatic run_transfer();
    logic [31:0] minsz;
    logic [31:0] proto_r;
    logic [31:0] cap;
    logic [31:0] umax;
    logic [31:0] len;
    logic [31:0] addr;
    logic [ctrc_pkg::STATUS_W-1:0] st;
    int n;
    int r;
    minsz   = (cfg_min == '0) ? 32'd1 : 32'(cfg_min);
    proto_r = (32'(cfg_proto) / minsz) * minsz;
    cap     = (32'(cfg_rmax) < proto_r) ? 32'(cfg_rmax) : proto_r;
    umax    = (4 * cap) / minsz;
    if (umax == 0) umax = 1;
    if (umax > 64) umax = 64;
    len = minsz * $urandom_range(1, umax);
    if ($urandom_range(7) == 0) begin
      addr = ((32'hFFFF_FFFF - (len - 32'd1)) / minsz) * minsz;
    end else begin
      addr = ($urandom() / minsz) * minsz;
    end
    send_item(ctrc_pkg::OP_START, addr, len, ctrc_pkg::STATUS_W'($urandom_range(0, 3)));
    n = 0;
    while (xfer_active && n < MAX_RESPONSES) begin
      if ($urandom_range(99) < 4) begin
        n = MAX_RESPONSES;  // abandon, the next start takes over
      end else begin
        r = $urandom_range(99);
        if (r < 72) st = ctrc_pkg::ST_OK;
        else if (r < 84) st = ctrc_pkg::ST_LINK;
        else if (r < 96) st = ctrc_pkg::ST_BUSY;
        else st = ctrc_pkg::ST_OTHER;
        send_item(ctrc_pkg::OP_RESPONSE, $urandom(), $urandom(), st);
        n++;
      end
    end
  endtask

  task automatic add_noise();
    int r;
    logic [31:0] minsz;
    minsz = (cfg_min == '0) ? 32'd1 : 32'(cfg_min);
    r = $urandom_range(99);
    if (r < 40) begin
      send_item(ctrc_pkg::OP_START, $urandom(),
                ($urandom_range(3) == 0) ? 32'd0 : $urandom(),
                ctrc_pkg::STATUS_W'($urandom_range(0, 3)));
    end else if (r < 70) begin
      send_item(ctrc_pkg::OP_RESPONSE, $urandom(), $urandom(),
                ctrc_pkg::STATUS_W'($urandom_range(0, 3)));
    end else begin
      send_item(ctrc_pkg::OP_START, $urandom(), $urandom_range(0, 3 * minsz),
                ctrc_pkg::STATUS_W'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_random_transfers();
    int unsigned base;
    logic [15:0] minv;
    logic [15:0] proto;
    logic [15:0] rmax;
    logic [15:0] step;
    logic [15:0] tmo;
    int r;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        apply_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1);
      end else if (ph == 1) begin
        apply_settings(16'd65535, 16'd4096, 16'd65535, 16'd16, 16'd65535, 16'd65535);
      end else begin
        r = $urandom_range(3);
        if (r == 0) minv = 16'd1;
        else if (r == 1) minv = 16'd1 << $urandom_range(0, 12);
        else if (r == 2) minv = 16'($urandom_range(1, 4096));
        else minv = 16'($urandom_range(1, 16));
        r = $urandom_range(99);
        if (r < 85) proto = 16'(minv * $urandom_range(1, 65535 / minv));
        else if (r < 97) proto = 16'($urandom_range(0, 65535));
        else proto = 16'd0;
        r = $urandom_range(9);
        if (r < 4) rmax = 16'd65535;
        else if (r < 7) rmax = 16'($urandom_range(1, 65535));
        else rmax = 16'($urandom_range(1, 256));
        r = $urandom_range(3);
        if (r < 2) step = 16'($urandom_range(1, 100));
        else if (r == 2) step = 16'($urandom_range(1, 65535));
        else step = 16'd65535;
        tmo = ($urandom_range(1) == 0) ? 16'($urandom_range(100, 65535))
                                       : 16'($urandom_range(1, 65535));
        apply_settings(proto, minv, rmax, 16'($urandom_range(0, 16)), step, tmo);
      end
      // one phase runs without any idling on either side
      idling = (ph != STEADY_PHASE);
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) run_transfer();
        else add_noise();
      end
    end
    idling = 1'b1;
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    op_i              = ctrc_pkg::OP_START;
    start_address_i   = '0;
    transfer_length_i = '0;
    response_status_i = ctrc_pkg::ST_OK;
    out_stall_i       = 1'b0;
    idling            = 1'b1;
    items_sent        = 0;
    fail_count        = 0;
    quiet_cycles      = 0;
    cfg_proto         = ctrc_pkg::RST_PROTO_MAX;
    cfg_min           = ctrc_pkg::RST_MIN_SIZE;
    cfg_rmax          = ctrc_pkg::RST_REGION_MAX;
    cfg_elimit        = ctrc_pkg::RST_ERR_LIMIT;
    cfg_step          = ctrc_pkg::RST_BUSY_STEP;
    cfg_timeout       = ctrc_pkg::RST_BUSY_TIMEOUT;
    next_addr         = '0;
    bytes_left        = '0;
    cur_chunk         = '0;
    err_win           = '0;
    busy_spent        = '0;
    xfer_active       = 1'b0;
    chunk_lim         = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_start_checks();
    test_limits();
    test_random_transfers();

    settle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("chunked_transfer_retry_controller regression: pass");
    end else begin
      $display("chunked_transfer_retry_controller regression: fail");
    end
    $finish;
  end

endmodule
